// ===== rtl/dhti_pkg.sv =====
// ----------------------------------------------------------------------------
// dhti_pkg
// Shared widths and defaults for the double-hashing table insert block.
// ----------------------------------------------------------------------------
`default_nettype none

package dhti_pkg;

	localparam int KEY_W          = 37;
	localparam int SLOT_W         = 11;
	localparam int CNT_W          = 11;
	localparam int SUM_W          = 20;
	localparam int TABLE_SIZE_DEF = 1201;

	localparam logic [SUM_W-1:0] SUM_MAX = '1;

endpackage

`default_nettype wire

// ===== rtl/dhti_req_if.sv =====
// ----------------------------------------------------------------------------
// dhti_req_if
// Key channel: one key per word, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface dhti_req_if;

	logic                      valid;
	logic                      ready;
	logic [dhti_pkg::KEY_W-1:0] key;

	modport source (output valid, output key, input ready);
	modport sink   (input valid, input key, output ready);

endinterface

`default_nettype wire

// ===== rtl/dhti_rsp_if.sv =====
// ----------------------------------------------------------------------------
// dhti_rsp_if
// Result channel: insert outcome and table statistics, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface dhti_rsp_if;

	logic                       valid;
	logic                       ready;
	logic                       status;
	logic [dhti_pkg::SLOT_W-1:0] slot;
	logic [dhti_pkg::SLOT_W-1:0] probe_count;
	logic [dhti_pkg::SUM_W-1:0]  collision_total;
	logic [dhti_pkg::CNT_W-1:0]  insert_count;
	logic [dhti_pkg::CNT_W-1:0]  empty_count;

	modport source (
		output valid, output status, output slot, output probe_count,
		output collision_total, output insert_count, output empty_count,
		input ready
	);
	modport sink (
		input valid, input status, input slot, input probe_count,
		input collision_total, input insert_count, input empty_count,
		output ready
	);

endinterface

`default_nettype wire

// ===== rtl/double_hash_table_insert_top.sv =====
// ----------------------------------------------------------------------------
// double_hash_table_insert_top
// Open-addressing insert with double hashing into a table RAM with one write and one read port.
//
//   channel  dir  payload                                      handshake
//   req      in   key                                          valid/ready
//   rsp      out  status, slot, probe_count, collision_total,  valid/ready
//                 insert_count, empty_count
//
// After reset a clearing pass writes every entry, with req held not ready.
// Each key then goes through the two remainders (byte fold by constant
// weights, reciprocal multiply, correcting subtract), the home read and the
// slot checks (read data registered, next address issued speculatively),
// then the hand-over. The table RAM read port sets the probe rate. One key
// is in work at a time; a result word waiting on rsp does not stop req
// taking the next key, only the hand-over of its result.
// ----------------------------------------------------------------------------
`default_nettype none

module double_hash_table_insert_top #(
	parameter int TABLE_SIZE = dhti_pkg::TABLE_SIZE_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	dhti_req_if.sink    req,
	dhti_rsp_if.source  rsp
);

	import dhti_pkg::*;

	localparam int AW       = $clog2(TABLE_SIZE);
	localparam int PW       = $clog2(TABLE_SIZE + 1);
	localparam int MW       = KEY_W + 1;
	localparam int NB       = (KEY_W + 7) / 8;
	localparam int FW       = AW + 11;
	localparam int QW       = FW - AW + 2;
	localparam int DIV_CYC  = 3;
	localparam int DCW      = $clog2(DIV_CYC);

	localparam logic [AW:0]   MOD_H   = (AW + 1)'(TABLE_SIZE);
	localparam logic [AW:0]   MOD_S   = (AW + 1)'(TABLE_SIZE - 1);
	localparam logic [AW-1:0] LAST_A  = AW'(TABLE_SIZE - 1);
	localparam logic [PW-1:0] LAST_P  = PW'(TABLE_SIZE - 1);
	localparam logic [PW-1:0] SIZE_P  = PW'(TABLE_SIZE);
	localparam logic [DCW-1:0] LAST_D = DCW'(DIV_CYC - 1);
	localparam logic [QW-1:0] MU_H    = QW'((64'd1 << FW) / TABLE_SIZE);
	localparam logic [QW-1:0] MU_S    = QW'((64'd1 << FW) / (TABLE_SIZE - 1));

	typedef enum logic [5:0] {
		S_CLR  = 6'b000001,
		S_IDLE = 6'b000010,
		S_DIV  = 6'b000100,
		S_RD   = 6'b001000,
		S_CHK  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t             state_q;
	logic [AW-1:0]      clr_q;
	logic [DCW-1:0]     div_q;
	logic [KEY_W-1:0]   key_q;
	logic [FW-1:0]      fh_q;
	logic [FW-1:0]      fs_q;
	logic [QW-1:0]      qh_q;
	logic [QW-1:0]      qs_q;
	logic [AW-1:0]      pos_q;
	logic [AW-1:0]      step_q;
	logic [PW-1:0]      probes_q;
	logic               fnd_q;
	logic [SUM_W-1:0]   sum_q;
	logic [PW-1:0]      cnt_q;

	logic [MW-1:0]      mem [TABLE_SIZE];
	logic [MW-1:0]      rd_q;
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	logic [MW-1:0]      mem_wd;
	logic [AW-1:0]      mem_ra;

	logic [FW-1:0]      fold_h;
	logic [FW-1:0]      fold_s;
	logic [FW+QW-1:0]   prod_h;
	logic [FW+QW-1:0]   prod_s;
	logic [AW-1:0]      rh_n;
	logic [AW-1:0]      rs_n;
	logic [AW-1:0]      pos_nx;
	logic [SUM_W:0]     sum_w;

	logic               rsp_v_q;
	logic               st_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [SLOT_W-1:0]  prb_q;
	logic [SUM_W-1:0]   tot_q;
	logic [CNT_W-1:0]   ins_q;
	logic [CNT_W-1:0]   emp_q;

	// 2^(8*i) mod m, by doubling
	function automatic logic [AW-1:0] byte_wt(input int i, input logic [AW:0] m);
		logic [AW:0] w;
		w = (AW + 1)'(1);
		for (int j = 0; j < 8 * i; j++) begin
			w = {w[AW-1:0], 1'b0};
			if (w >= m) begin
				w = w - m;
			end
		end
		return w[AW-1:0];
	endfunction

	// key bytes folded by their weights, below 2^FW
	always_comb begin
		logic [FW-1:0] acc_h;
		logic [FW-1:0] acc_s;
		logic [FW-1:0] kb;
		acc_h = '0;
		acc_s = '0;
		for (int i = 0; i < NB; i++) begin
			kb    = FW'(8'(key_q >> (8 * i)));
			acc_h = acc_h + kb * FW'(byte_wt(i, MOD_H));
			acc_s = acc_s + kb * FW'(byte_wt(i, MOD_S));
		end
		fold_h = acc_h;
		fold_s = acc_s;
	end

	// quotient estimate, low by at most one
	assign prod_h = (FW + QW)'(fh_q) * (FW + QW)'(MU_H);
	assign prod_s = (FW + QW)'(fs_q) * (FW + QW)'(MU_S);

	always_comb begin
		logic [FW-1:0] dh;
		logic [FW-1:0] ds;
		logic [AW:0]   th;
		logic [AW:0]   ts;
		dh = fh_q - FW'(qh_q) * FW'(MOD_H);
		ds = fs_q - FW'(qs_q) * FW'(MOD_S);
		th = dh[AW:0];
		ts = ds[AW:0];
		if (th >= MOD_H) begin
			th = th - MOD_H;
		end
		if (ts >= MOD_S) begin
			ts = ts - MOD_S;
		end
		rh_n = th[AW-1:0];
		rs_n = ts[AW-1:0];
	end

	always_comb begin
		logic [AW:0] ps;
		ps = {1'b0, pos_q} + {1'b0, step_q};
		if (ps >= MOD_H) begin
			ps = ps - MOD_H;
		end
		pos_nx = ps[AW-1:0];
	end

	assign sum_w = {1'b0, sum_q} + (SUM_W + 1)'(probes_q);

	assign mem_ra = (state_q == S_CHK) ? pos_nx : pos_q;
	assign mem_we = (state_q == S_CLR) || ((state_q == S_CHK) && !rd_q[KEY_W]);
	assign mem_wa = (state_q == S_CLR) ? clr_q : pos_q;
	assign mem_wd = (state_q == S_CLR) ? '0 : {1'b1, key_q};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			clr_q    <= '0;
			div_q    <= '0;
			fnd_q    <= 1'b0;
			sum_q    <= '0;
			cnt_q    <= '0;
			probes_q <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_A) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						div_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					div_q <= div_q + 1'b1;
					if (div_q == LAST_D) begin
						probes_q <= '0;
						state_q  <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (!rd_q[KEY_W]) begin
						fnd_q   <= 1'b1;
						cnt_q   <= cnt_q + 1'b1;
						sum_q   <= (sum_w > {1'b0, SUM_MAX}) ? SUM_MAX : sum_w[SUM_W-1:0];
						state_q <= S_DONE;
					end else begin
						probes_q <= probes_q + 1'b1;
						if (probes_q == LAST_P) begin
							fnd_q   <= 1'b0;
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (!rsp_v_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLR;
				end
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && req.valid) begin
			key_q <= req.key;
		end
		if (state_q == S_DIV) begin
			fh_q <= fold_h;
			fs_q <= fold_s;
			qh_q <= prod_h[FW+QW-1:FW];
			qs_q <= prod_s[FW+QW-1:FW];
			if (div_q == LAST_D) begin
				pos_q  <= rh_n;
				step_q <= rs_n + 1'b1;
			end
		end
		if ((state_q == S_CHK) && rd_q[KEY_W] && (probes_q != LAST_P)) begin
			pos_q <= pos_nx;
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if ((state_q == S_DONE) && (!rsp_v_q || rsp.ready)) begin
			rsp_v_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && (!rsp_v_q || rsp.ready)) begin
			st_q   <= !fnd_q;
			slot_q <= fnd_q ? SLOT_W'(pos_q) : '0;
			prb_q  <= SLOT_W'(probes_q);
			tot_q  <= sum_q;
			ins_q  <= CNT_W'(cnt_q);
			emp_q  <= CNT_W'(SIZE_P - cnt_q);
		end
	end

	assign req.ready           = (state_q == S_IDLE);
	assign rsp.valid           = rsp_v_q;
	assign rsp.status          = st_q;
	assign rsp.slot            = slot_q;
	assign rsp.probe_count     = prb_q;
	assign rsp.collision_total = tot_q;
	assign rsp.insert_count    = ins_q;
	assign rsp.empty_count     = emp_q;

endmodule

`default_nettype wire
